@@ src/assert_macros.svh @@
// Concurrent assertion helpers, sampled on clk and idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pwmtb_pkg.sv @@
package pwmtb_pkg;

	localparam int ENTRIES      = 4;
	localparam int ENT_W        = $clog2(ENTRIES);
	localparam int MAX_CHANNELS = 8;
	localparam int CH_W         = 3;
	localparam int COUNT_W      = 4;
	localparam int DIV_W        = 32;
	localparam int DUTY_W       = 17;
	localparam int VAL_W        = 16;
	localparam int FRAC_W       = 16;
	localparam int PROD_W       = 2 * DUTY_W;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;
	localparam logic [VAL_W-1:0] LIMIT16 = 16'hffff;

	localparam logic [DIV_W-1:0]        CLOCK_HZ_RST = 32'd40000000;
	localparam logic [COUNT_W-1:0]      CHAN_COUNT_RST = 4'd8;
	localparam logic [MAX_CHANNELS-1:0] WIRED_RST = 8'hff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLOCK_HZ      = 2'd0,
		REG_CHANNEL_COUNT = 2'd1,
		REG_WIRED_MASK    = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_ERROR    = 2'd0,
		KIND_TIMEBASE = 2'd1,
		KIND_CHANNEL  = 2'd2,
		KIND_STOPPED  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		TB_UNCHANGED = 2'd0,
		TB_INIT      = 2'd1,
		TB_HOT       = 2'd2
	} tb_action_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV1,
		S_PSC,
		S_DIV2,
		S_TB,
		S_SCAN,
		S_MUL,
		S_CH,
		S_STOP,
		S_ERR
	} state_t;

	typedef struct packed {
		kind_t                   kind;
		tb_action_t              tb_action;
		logic [VAL_W-1:0]        prescale;
		logic [VAL_W-1:0]        reload;
		logic [CH_W-1:0]         hw_channel;
		logic [VAL_W-1:0]        compare;
		logic                    newly_enabled;
		logic                    timer_enable;
		logic [MAX_CHANNELS-1:0] disable_mask;
		logic                    last;
	} res_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic [COUNT_W-1:0] eff_count(logic [COUNT_W-1:0] count);
		return (count > COUNT_W'(MAX_CHANNELS)) ? COUNT_W'(MAX_CHANNELS) : count;
	endfunction

	function automatic logic [MAX_CHANNELS-1:0] count_mask(logic [COUNT_W-1:0] count);
		logic [MAX_CHANNELS-1:0] m;
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			m[i] = (COUNT_W'(i) < count);
		end
		return m;
	endfunction

	function automatic logic entry_usable(logic [7:0] chan, logic [COUNT_W-1:0] count,
			logic [MAX_CHANNELS-1:0] wired);
		logic [CH_W-1:0] hw;
		hw = chan[CH_W-1:0] - CH_W'(1);
		return !chan[7] && (chan != 8'd0) && (chan[6:0] <= 7'(count)) && wired[hw];
	endfunction

endpackage

@@ src/pwmtb_req_if.sv @@
interface pwmtb_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] frequency;
	logic [7:0]  chan_a;
	logic [16:0] duty_a;
	logic [7:0]  chan_b;
	logic [16:0] duty_b;
	logic [7:0]  chan_c;
	logic [16:0] duty_c;
	logic [7:0]  chan_d;
	logic [16:0] duty_d;

	modport source (
		output valid, mode, frequency, chan_a, duty_a, chan_b, duty_b,
			chan_c, duty_c, chan_d, duty_d,
		input  ready
	);
	modport sink (
		input  valid, mode, frequency, chan_a, duty_a, chan_b, duty_b,
			chan_c, duty_c, chan_d, duty_d,
		output ready
	);
endinterface

@@ src/pwmtb_res_if.sv @@
interface pwmtb_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  tb_action;
	logic [15:0] prescale;
	logic [15:0] reload;
	logic [2:0]  hw_channel;
	logic [15:0] compare;
	logic        newly_enabled;
	logic        timer_enable;
	logic [7:0]  disable_mask;
	logic        last;

	modport source (
		output valid, kind, tb_action, prescale, reload, hw_channel, compare,
			newly_enabled, timer_enable, disable_mask, last,
		input  ready
	);
	modport sink (
		input  valid, kind, tb_action, prescale, reload, hw_channel, compare,
			newly_enabled, timer_enable, disable_mask, last,
		output ready
	);
endinterface

@@ src/pwmtb_div.sv @@
module pwmtb_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pwmtb_pkg::unit_ctl_t            ctl,
	input  logic [pwmtb_pkg::DIV_W-1:0]     dividend,
	input  logic [pwmtb_pkg::DIV_W-1:0]     divisor,
	output pwmtb_pkg::unit_stat_t           stat,
	output logic [pwmtb_pkg::DIV_W-1:0]     quotient
);

	localparam int W   = pwmtb_pkg::DIV_W;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dsr_q;

	logic [W:0]       shifted;
	logic [W+1:0]     diff;
	logic             ge;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = {1'b0, shifted} - {2'b00, dsr_q};
		ge      = !diff[W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

@@ src/pwmtb_mul.sv @@
module pwmtb_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pwmtb_pkg::unit_ctl_t            ctl,
	input  logic [pwmtb_pkg::DUTY_W-1:0]    mcand,
	input  logic [pwmtb_pkg::DUTY_W-1:0]    mplier,
	output pwmtb_pkg::unit_stat_t           stat,
	output logic [pwmtb_pkg::PROD_W-1:0]    product
);

	localparam int W     = pwmtb_pkg::DUTY_W;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     mcand_q;
	logic [W-1:0]     hi_q;
	logic [W-1:0]     lo_q;
	logic [W:0]       sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q <= mcand;
			hi_q    <= '0;
			lo_q    <= mplier;
		end else if (busy_q) begin
			hi_q <= sum[W:1];
			lo_q <= {sum[0], lo_q[W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = {hi_q, lo_q};

endmodule

@@ src/pwm_timebase_duty_planner_top.sv @@
// Channel  Role    Carries
// cfg      write   cfg_we, cfg_idx, cfg_wdata (clock_hz, channel_count, wired_mask)
// req      sink    mode, frequency, four channel/duty pairs
// res      source  kind, tb_action, prescale, reload, hw_channel, compare, flags, last
//
// A start transaction loads its timebase result after two bit-serial 32-bit divisions, a
// prescale step between them and an emit step. Each usable entry adds a serial multiply,
// a scan and an emit step; a skipped entry ahead of a usable one is stepped over in the
// scan state, trailing ones are never scanned. Stop and error transactions load their
// result from the stop or error state entered on accept. Reset restores the default
// configuration and idles the run state. A stalled result holds the planner in its emit
// state until the output register frees.
`include "assert_macros.svh"

module pwm_timebase_duty_planner_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pwmtb_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [pwmtb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	pwmtb_req_if.sink                            req,
	pwmtb_res_if.source                          res
);

	localparam int ENTRIES = pwmtb_pkg::ENTRIES;
	localparam int ENT_W   = pwmtb_pkg::ENT_W;
	localparam int NCH     = pwmtb_pkg::MAX_CHANNELS;
	localparam int CH_W    = pwmtb_pkg::CH_W;
	localparam int VAL_W   = pwmtb_pkg::VAL_W;
	localparam int DIV_W   = pwmtb_pkg::DIV_W;
	localparam int DUTY_W  = pwmtb_pkg::DUTY_W;
	localparam int PROD_W  = pwmtb_pkg::PROD_W;
	localparam int FRAC_W  = pwmtb_pkg::FRAC_W;
	localparam int COUNT_W = pwmtb_pkg::COUNT_W;

	logic [DIV_W-1:0]   clock_hz_q;
	logic [COUNT_W-1:0] chan_count_q;
	logic [NCH-1:0]     wired_q;

	pwmtb_pkg::state_t  state_q, state_d;
	logic               running_q;
	logic [DIV_W-1:0]   cur_freq_q;
	logic [NCH-1:0]     enabled_q;
	logic [VAL_W-1:0]   cur_prescale_q;
	logic [VAL_W-1:0]   cur_reload_q;

	logic [DIV_W-1:0]   freq_q;
	logic [7:0]         chan_q [ENTRIES];
	logic [DUTY_W-1:0]  duty_q [ENTRIES];
	logic [ENTRIES-1:0] usable_q;
	logic [ENT_W-1:0]   idx_q;

	pwmtb_pkg::res_t    res_q, res_d;
	logic               res_valid_q;
	logic               res_load;
	logic               slot_free;
	logic               accept;

	logic [7:0]         chan_in [ENTRIES];
	logic [DUTY_W-1:0]  duty_in [ENTRIES];
	logic [COUNT_W-1:0] count_eff;

	pwmtb_pkg::unit_ctl_t  div_ctl, mul_ctl;
	pwmtb_pkg::unit_stat_t div_stat, mul_stat;
	logic [DIV_W-1:0]   div_dividend, div_divisor, div_quo;
	logic [PROD_W-1:0]  mul_prod;
	logic [DUTY_W-1:0]  mul_mplier;

	logic [VAL_W-1:0]   psc_new;
	logic [DIV_W-1:0]   ticks_m1;
	logic [DIV_W-1:0]   a_adj, a_m1;
	logic [VAL_W-1:0]   reload_new;
	logic [PROD_W-FRAC_W-1:0] prod_hi;
	logic [VAL_W-1:0]   cmp_val;
	logic [CH_W-1:0]    hw_cur;
	logic [ENTRIES-1:0] rest;

	logic               div_wait;
	logic               ch_load;
	logic               stop_load;
	logic               res_is_ch;
	logic               run_clear;

	assign chan_in[0] = req.chan_a;
	assign chan_in[1] = req.chan_b;
	assign chan_in[2] = req.chan_c;
	assign chan_in[3] = req.chan_d;
	assign duty_in[0] = req.duty_a;
	assign duty_in[1] = req.duty_b;
	assign duty_in[2] = req.duty_c;
	assign duty_in[3] = req.duty_d;

	assign count_eff = pwmtb_pkg::eff_count(chan_count_q);
	assign req.ready = (state_q == pwmtb_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !res_valid_q || res.ready;

	assign ticks_m1   = div_quo - DIV_W'(1);
	assign psc_new    = ticks_m1[DIV_W-1:FRAC_W];
	assign a_adj      = (div_quo == '0) ? DIV_W'(1) : div_quo;
	assign a_m1       = a_adj - DIV_W'(1);
	assign reload_new = (a_m1[DIV_W-1:VAL_W] != '0) ? pwmtb_pkg::LIMIT16 : a_m1[VAL_W-1:0];

	assign mul_mplier = {1'b0, cur_reload_q} + DUTY_W'(1);
	assign prod_hi    = mul_prod[PROD_W-1:FRAC_W];
	assign cmp_val    = (prod_hi > (PROD_W-FRAC_W)'(cur_reload_q)) ? cur_reload_q
		: prod_hi[VAL_W-1:0];
	assign hw_cur     = chan_q[idx_q][CH_W-1:0] - CH_W'(1);
	assign rest       = usable_q >> idx_q;

	pwmtb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	pwmtb_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mul_ctl),
		.mcand   (duty_q[idx_q]),
		.mplier  (mul_mplier),
		.stat    (mul_stat),
		.product (mul_prod)
	);

	always_comb begin
		state_d       = state_q;
		div_ctl.start = 1'b0;
		mul_ctl.start = 1'b0;
		div_dividend  = clock_hz_q;
		div_divisor   = req.frequency;
		res_load      = 1'b0;
		res_d         = '0;
		unique case (state_q)
			pwmtb_pkg::S_IDLE: begin
				if (accept) begin
					if (req.mode) begin
						state_d = pwmtb_pkg::S_STOP;
					end else if (req.frequency == '0 || req.frequency > clock_hz_q) begin
						state_d = pwmtb_pkg::S_ERR;
					end else begin
						div_ctl.start = 1'b1;
						state_d       = pwmtb_pkg::S_DIV1;
					end
				end
			end
			pwmtb_pkg::S_DIV1: begin
				if (div_stat.done) begin
					state_d = pwmtb_pkg::S_PSC;
				end
			end
			pwmtb_pkg::S_PSC: begin
				div_dividend  = div_quo;
				div_divisor   = DIV_W'(psc_new) + DIV_W'(1);
				div_ctl.start = 1'b1;
				state_d       = pwmtb_pkg::S_DIV2;
			end
			pwmtb_pkg::S_DIV2: begin
				if (div_stat.done) begin
					state_d = pwmtb_pkg::S_TB;
				end
			end
			pwmtb_pkg::S_TB: begin
				res_d.kind         = pwmtb_pkg::KIND_TIMEBASE;
				res_d.tb_action    = !running_q ? pwmtb_pkg::TB_INIT
					: (freq_q != cur_freq_q) ? pwmtb_pkg::TB_HOT : pwmtb_pkg::TB_UNCHANGED;
				res_d.prescale     = cur_prescale_q;
				res_d.reload       = cur_reload_q;
				res_d.timer_enable = !running_q;
				res_d.last         = (usable_q == '0);
				if (slot_free) begin
					res_load = 1'b1;
					state_d  = (usable_q == '0) ? pwmtb_pkg::S_IDLE : pwmtb_pkg::S_SCAN;
				end
			end
			pwmtb_pkg::S_SCAN: begin
				if (usable_q[idx_q]) begin
					mul_ctl.start = 1'b1;
					state_d       = pwmtb_pkg::S_MUL;
				end
			end
			pwmtb_pkg::S_MUL: begin
				if (mul_stat.done) begin
					state_d = pwmtb_pkg::S_CH;
				end
			end
			pwmtb_pkg::S_CH: begin
				res_d.kind          = pwmtb_pkg::KIND_CHANNEL;
				res_d.prescale      = cur_prescale_q;
				res_d.reload        = cur_reload_q;
				res_d.hw_channel    = hw_cur;
				res_d.compare       = cmp_val;
				res_d.newly_enabled = !enabled_q[hw_cur];
				res_d.last          = (rest[ENTRIES-1:1] == '0);
				if (slot_free) begin
					res_load = 1'b1;
					state_d  = (rest[ENTRIES-1:1] == '0) ? pwmtb_pkg::S_IDLE
						: pwmtb_pkg::S_SCAN;
				end
			end
			pwmtb_pkg::S_STOP: begin
				res_d.kind         = pwmtb_pkg::KIND_STOPPED;
				res_d.prescale     = cur_prescale_q;
				res_d.reload       = cur_reload_q;
				res_d.disable_mask = enabled_q & pwmtb_pkg::count_mask(count_eff);
				res_d.last         = 1'b1;
				if (slot_free) begin
					res_load = 1'b1;
					state_d  = pwmtb_pkg::S_IDLE;
				end
			end
			pwmtb_pkg::S_ERR: begin
				res_d.kind = pwmtb_pkg::KIND_ERROR;
				res_d.last = 1'b1;
				if (slot_free) begin
					res_load = 1'b1;
					state_d  = pwmtb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pwmtb_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwmtb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q   <= pwmtb_pkg::CLOCK_HZ_RST;
			chan_count_q <= pwmtb_pkg::CHAN_COUNT_RST;
			wired_q      <= pwmtb_pkg::WIRED_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pwmtb_pkg::REG_CLOCK_HZ:      clock_hz_q   <= cfg_wdata[DIV_W-1:0];
				pwmtb_pkg::REG_CHANNEL_COUNT: chan_count_q <= cfg_wdata[COUNT_W-1:0];
				pwmtb_pkg::REG_WIRED_MASK:    wired_q      <= cfg_wdata[NCH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q      <= 1'b0;
			cur_freq_q     <= '0;
			enabled_q      <= '0;
			cur_prescale_q <= '0;
			cur_reload_q   <= '0;
			usable_q       <= '0;
			idx_q          <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				for (int i = 0; i < ENTRIES; i++) begin
					usable_q[i] <= pwmtb_pkg::entry_usable(chan_in[i], count_eff, wired_q);
				end
			end
			if (state_q == pwmtb_pkg::S_PSC) begin
				cur_prescale_q <= psc_new;
			end
			if (state_q == pwmtb_pkg::S_DIV2 && div_stat.done) begin
				cur_reload_q <= reload_new;
			end
			if (state_q == pwmtb_pkg::S_SCAN && !usable_q[idx_q]) begin
				idx_q <= idx_q + ENT_W'(1);
			end
			if (res_load) begin
				unique case (state_q)
					pwmtb_pkg::S_TB: begin
						running_q  <= 1'b1;
						cur_freq_q <= freq_q;
						idx_q      <= '0;
					end
					pwmtb_pkg::S_CH: begin
						enabled_q[hw_cur] <= 1'b1;
						idx_q             <= idx_q + ENT_W'(1);
					end
					pwmtb_pkg::S_STOP: begin
						running_q  <= 1'b0;
						cur_freq_q <= '0;
						enabled_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			freq_q <= req.frequency;
			for (int i = 0; i < ENTRIES; i++) begin
				chan_q[i] <= chan_in[i];
				duty_q[i] <= duty_in[i];
			end
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.kind          = res_q.kind;
	assign res.tb_action     = res_q.tb_action;
	assign res.prescale      = res_q.prescale;
	assign res.reload        = res_q.reload;
	assign res.hw_channel    = res_q.hw_channel;
	assign res.compare       = res_q.compare;
	assign res.newly_enabled = res_q.newly_enabled;
	assign res.timer_enable  = res_q.timer_enable;
	assign res.disable_mask  = res_q.disable_mask;
	assign res.last          = res_q.last;

	assign div_wait  = (state_q == pwmtb_pkg::S_DIV1) || (state_q == pwmtb_pkg::S_DIV2);
	assign ch_load   = res_load && (state_q == pwmtb_pkg::S_CH);
	assign stop_load = res_load && (state_q == pwmtb_pkg::S_STOP);
	assign res_is_ch = res_valid_q && (res_q.kind == pwmtb_pkg::KIND_CHANNEL);
	assign run_clear = !running_q && (enabled_q == '0) && (cur_freq_q == '0);

	`ASSERT_IMPLIES(a_div_done_owned, div_stat.done, div_wait, "divider done outside a divide")
	`ASSERT_NEXT(a_ch_enables, ch_load, enabled_q[res_q.hw_channel], "channel left disabled")
	`ASSERT_IMPLIES(a_cmp_clamped, res_is_ch, res_q.compare <= res_q.reload, "compare above reload")
	`ASSERT_NEXT(a_stop_clears, stop_load, run_clear, "stop left run state behind")

endmodule
